[rtl/core/apsx_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// apsx_pkg: shared types and constants of the parameter-set extractor
// Record layout constants, status and function codes, the parser state and
// the per-byte step functions used by the extractor datapath.
// ============================================================================
package apsx_pkg;

    // Parameter-set store geometry
    localparam int MAX_SET_BYTES = 256;
    localparam int SET_AW        = $clog2(MAX_SET_BYTES);
    localparam int CNT_W         = SET_AW + 1;

    // A request touches at most five body bytes: one shifted out of the window
    // plus a full window flushed at the end of a buffer.
    localparam int NUM_SLOTS = 5;
    localparam int NUM_BANKS = 8;
    localparam int BANK_AW   = $clog2(NUM_BANKS);
    localparam int ROW_AW    = SET_AW - BANK_AW;
    localparam int BANK_ROWS = MAX_SET_BYTES / NUM_BANKS;

    // Lookahead window
    localparam int WIN_DEPTH = 4;
    localparam int FILL_W    = 3;

    // Port field widths
    localparam int STATUS_W = 3;
    localparam int LEN_W    = 10;
    localparam int BYTE_W   = 8;

    typedef logic [BYTE_W-1:0]   byte_t;
    typedef logic [LEN_W-1:0]    len_t;
    typedef logic [CNT_W-1:0]    cnt_t;
    typedef logic [SET_AW-1:0]   addr_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [FILL_W-1:0]   fill_t;

    // Request function codes
    localparam logic FUNC_STREAM = 1'b0;
    localparam logic FUNC_READ   = 1'b1;

    // Result status codes
    localparam status_t ST_OK        = 3'd0;
    localparam status_t ST_MISSING   = 3'd1;
    localparam status_t ST_TOO_LONG  = 3'd2;
    localparam status_t ST_SPS_SHORT = 3'd3;
    localparam status_t ST_NO_RECORD = 3'd4;

    // NAL header
    localparam logic [4:0] NAL_TYPE_SPS = 5'd7;
    localparam logic [4:0] NAL_TYPE_PPS = 5'd8;

    // Fixed avcC bytes
    localparam byte_t REC_VERSION  = 8'h01;
    localparam byte_t REC_LEN_SIZE = 8'hFF;
    localparam byte_t REC_NUM_SPS  = 8'hE1;
    localparam byte_t REC_NUM_PPS  = 8'h01;
    localparam len_t  REC_FIXED    = 10'd11;
    localparam cnt_t  SPS_MIN      = 9'd4;
    localparam cnt_t  SET_LIMIT    = cnt_t'(MAX_SET_BYTES);

    // Where the bytes of the current NAL go
    typedef enum logic [3:0] {
        TGT_NONE = 4'b0001,
        TGT_SPS  = 4'b0010,
        TGT_PPS  = 4'b0100,
        TGT_SKIP = 4'b1000
    } target_t;

    // Parser state carried from byte to byte
    typedef struct packed {
        logic    found_sps;
        logic    found_pps;
        logic    done;
        target_t target;
        logic    at_first;
        cnt_t    sps_cnt;
        cnt_t    pps_cnt;
    } proc_t;

    // One body byte processed: new state and the store write it causes
    typedef struct packed {
        proc_t st;
        logic  we;
        logic  to_pps;
        addr_t addr;
        byte_t data;
    } bstep_t;

    // Slot that carries no byte
    function automatic bstep_t idle_step(proc_t st);
        bstep_t r;
        r.st     = st;
        r.we     = 1'b0;
        r.to_pps = 1'b0;
        r.addr   = '0;
        r.data   = '0;
        return r;
    endfunction

    // A byte known to belong to the current NAL body
    function automatic bstep_t body_step(proc_t st, byte_t b);
        bstep_t     r;
        logic [4:0] t;
        r = idle_step(st);
        r.data = b;
        t = b[4:0];
        if (!st.done) begin
            // first byte decides where the NAL goes
            if (st.at_first) begin
                r.st.at_first = 1'b0;
                if (t == NAL_TYPE_SPS && !st.found_sps) begin
                    r.st.found_sps = 1'b1;
                    r.st.target    = TGT_SPS;
                    r.st.sps_cnt   = '0;
                end
                else if (t == NAL_TYPE_PPS && !st.found_pps) begin
                    r.st.found_pps = 1'b1;
                    r.st.target    = TGT_PPS;
                    r.st.pps_cnt   = '0;
                end
                else begin
                    r.st.target = TGT_SKIP;
                end
            end
            // capture, count saturates one above the limit
            if (r.st.target == TGT_SPS) begin
                if (r.st.sps_cnt < SET_LIMIT) begin
                    r.we   = 1'b1;
                    r.addr = r.st.sps_cnt[SET_AW-1:0];
                end
                if (r.st.sps_cnt <= SET_LIMIT) begin
                    r.st.sps_cnt = r.st.sps_cnt + cnt_t'(1);
                end
            end
            else if (r.st.target == TGT_PPS) begin
                if (r.st.pps_cnt < SET_LIMIT) begin
                    r.we     = 1'b1;
                    r.to_pps = 1'b1;
                    r.addr   = r.st.pps_cnt[SET_AW-1:0];
                end
                if (r.st.pps_cnt <= SET_LIMIT) begin
                    r.st.pps_cnt = r.st.pps_cnt + cnt_t'(1);
                end
            end
        end
        return r;
    endfunction

    // A counted start code closes the NAL; empty NAL or full pair ends search
    function automatic proc_t start_code(proc_t st);
        proc_t r;
        r = st;
        if (!st.done) begin
            r.target = TGT_NONE;
            if (st.at_first || (st.found_sps && st.found_pps)) begin
                r.done     = 1'b1;
                r.at_first = 1'b0;
            end
            else begin
                r.at_first = 1'b1;
            end
        end
        return r;
    endfunction

endpackage

[rtl/core/apsx_ifs.sv]
`timescale 1ns / 1ps
// ============================================================================
// apsx_ifs: request and result channels of the parameter-set extractor
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ============================================================================
interface apsx_req_if;
    logic                 valid;
    logic                 ready;
    logic                 func;
    apsx_pkg::byte_t      data_byte;
    logic                 last_byte;

    modport source (output valid, output func, output data_byte, output last_byte,
                    input ready);
    modport sink   (input valid, input func, input data_byte, input last_byte,
                    output ready);
endinterface

interface apsx_rsp_if;
    logic                 valid;
    logic                 ready;
    apsx_pkg::status_t    status;
    apsx_pkg::len_t       record_length;
    apsx_pkg::byte_t      record_byte;
    logic                 record_last;

    modport source (output valid, output status, output record_length,
                    output record_byte, output record_last, input ready);
    modport sink   (input valid, input status, input record_length,
                    input record_byte, input record_last, output ready);
endinterface

[rtl/core/annexb_param_set_extractor_unit.sv]
`timescale 1ns / 1ps
// ============================================================================
// annexb_param_set_extractor_unit: Annex B to avcC parameter-set extractor
// Scans an Annex B buffer for the first SPS and PPS and returns the avcC
// decoder configuration record one byte per read request.
// ============================================================================
// Every request, stream byte or record read, is handled in the cycle it is
// taken, and the block accepts a request on every clock while its two-entry
// result queue has room; a result is registered in the queue before it shows
// on rsp. The start-code search runs on a four-byte lookahead window, and at
// the end of a buffer the whole window is flushed into the stores in the same
// cycle, which is why each store is split into eight banks of 32 bytes with one
// write port each. Record bytes come from a read register that is loaded from
// the read index ahead of the request, so reads also stream at one byte per
// cycle while the queue has room. No clearing pass is needed after reset.
module annexb_param_set_extractor_unit (
    input  logic       clk,
    input  logic       rst_n,
    apsx_req_if.sink   req,
    apsx_rsp_if.source rsp
);

    typedef struct packed {
        apsx_pkg::status_t status;
        apsx_pkg::len_t    length;
        apsx_pkg::byte_t   rbyte;
        logic              rlast;
    } res_t;

    // Handshake
    logic req_fire;
    logic st_req;
    logic rd_req;
    logic rsp_fire;

    // Registered state
    apsx_pkg::proc_t proc_reg, proc_next;
    apsx_pkg::byte_t win_reg [apsx_pkg::WIN_DEPTH];
    apsx_pkg::byte_t win_next [apsx_pkg::WIN_DEPTH];
    apsx_pkg::fill_t fill_reg, fill_next;
    apsx_pkg::len_t  idx_reg, idx_next;
    logic            ready_reg, ready_next;

    // Window and parse chain
    logic              c3, c4, sc, pre_valid;
    apsx_pkg::byte_t   nwin [apsx_pkg::WIN_DEPTH];
    apsx_pkg::fill_t   nfill;
    apsx_pkg::bstep_t  slot [apsx_pkg::NUM_SLOTS];
    apsx_pkg::proc_t   fin;
    apsx_pkg::proc_t   fin_clr;
    apsx_pkg::status_t end_status;
    apsx_pkg::len_t    end_len;

    // Store ports
    logic                        sps_we    [apsx_pkg::NUM_BANKS];
    logic                        pps_we    [apsx_pkg::NUM_BANKS];
    logic [apsx_pkg::ROW_AW-1:0] sps_wrow  [apsx_pkg::NUM_BANKS];
    logic [apsx_pkg::ROW_AW-1:0] pps_wrow  [apsx_pkg::NUM_BANKS];
    apsx_pkg::byte_t             sps_wdata [apsx_pkg::NUM_BANKS];
    apsx_pkg::byte_t             pps_wdata [apsx_pkg::NUM_BANKS];
    apsx_pkg::byte_t             sps_bank_q [apsx_pkg::NUM_BANKS];
    apsx_pkg::byte_t             pps_bank_q [apsx_pkg::NUM_BANKS];
    apsx_pkg::len_t              sps_ra_full, pps_ra_full;
    apsx_pkg::addr_t             sps_raddr, pps_raddr;
    logic [apsx_pkg::BANK_AW-1:0] sps_bsel_reg, pps_bsel_reg;

    // Readout
    apsx_pkg::len_t  s_ext, p_ext, rec_len;
    apsx_pkg::byte_t sps_q, pps_q, rd_byte;
    logic            rd_last;

    // Result queue
    res_t       q_reg [2];
    res_t       res_in;
    logic       push;
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg;

    assign req_fire = req.valid && req.ready;
    assign st_req   = req_fire && (req.func == apsx_pkg::FUNC_STREAM);
    assign rd_req   = req_fire && (req.func == apsx_pkg::FUNC_READ);
    assign rsp_fire = rsp.valid && rsp.ready;

    // Start-code detection and window update
    always_comb
    begin
        c4 = (fill_reg == apsx_pkg::fill_t'(4)) && (win_reg[0] == 8'h00) &&
             (win_reg[1] == 8'h00) && (win_reg[2] == 8'h00) && (win_reg[3] == 8'h01);
        c3 = 1'b0;
        if (fill_reg == apsx_pkg::fill_t'(3))
        begin
            c3 = (win_reg[0] == 8'h00) && (win_reg[1] == 8'h00) && (win_reg[2] == 8'h01);
        end
        else if (fill_reg == apsx_pkg::fill_t'(4))
        begin
            c3 = (win_reg[1] == 8'h00) && (win_reg[2] == 8'h00) && (win_reg[3] == 8'h01);
        end
        sc = c4 || c3;
        // oldest byte leaves the window: shifted out, or the byte ahead of a
        // three-byte code in a full window
        pre_valid = (fill_reg == apsx_pkg::fill_t'(4)) && !c4;

        nwin  = win_reg;
        nfill = fill_reg + apsx_pkg::fill_t'(1);
        if (sc)
        begin
            nwin[0] = req.data_byte;
            nfill   = apsx_pkg::fill_t'(1);
        end
        else if (fill_reg == apsx_pkg::fill_t'(4))
        begin
            nwin[0] = win_reg[1];
            nwin[1] = win_reg[2];
            nwin[2] = win_reg[3];
            nwin[3] = req.data_byte;
            nfill   = apsx_pkg::fill_t'(4);
        end
        else
        begin
            nwin[fill_reg[1:0]] = req.data_byte;
        end
    end

    // Body-byte chain: one pre byte, start code, then end-of-buffer flush
    always_comb
    begin
        apsx_pkg::proc_t cur;
        if (pre_valid)
        begin
            slot[0] = apsx_pkg::body_step(proc_reg, win_reg[0]);
        end
        else
        begin
            slot[0] = apsx_pkg::idle_step(proc_reg);
        end
        cur = sc ? apsx_pkg::start_code(slot[0].st) : slot[0].st;
        for (int j = 0; j < apsx_pkg::WIN_DEPTH; j++)
        begin
            if (req.last_byte && (apsx_pkg::fill_t'(j) < nfill))
            begin
                slot[j+1] = apsx_pkg::body_step(cur, nwin[j]);
            end
            else
            begin
                slot[j+1] = apsx_pkg::idle_step(cur);
            end
            cur = slot[j+1].st;
        end
        fin = cur;

        // end-of-buffer verdict
        if (!(fin.found_sps && fin.found_pps))
        begin
            end_status = apsx_pkg::ST_MISSING;
        end
        else if ((fin.sps_cnt > apsx_pkg::SET_LIMIT) || (fin.pps_cnt > apsx_pkg::SET_LIMIT))
        begin
            end_status = apsx_pkg::ST_TOO_LONG;
        end
        else if (fin.sps_cnt < apsx_pkg::SPS_MIN)
        begin
            end_status = apsx_pkg::ST_SPS_SHORT;
        end
        else
        begin
            end_status = apsx_pkg::ST_OK;
        end
        end_len = (end_status == apsx_pkg::ST_OK) ?
                  apsx_pkg::REC_FIXED + apsx_pkg::len_t'(fin.sps_cnt) +
                  apsx_pkg::len_t'(fin.pps_cnt) : '0;

        fin_clr           = fin;
        fin_clr.found_sps = 1'b0;
        fin_clr.found_pps = 1'b0;
        fin_clr.done      = 1'b0;
        fin_clr.target    = apsx_pkg::TGT_NONE;
        fin_clr.at_first  = 1'b0;
    end

    // Bank write steering: consecutive addresses land in distinct banks
    always_comb
    begin
        for (int g = 0; g < apsx_pkg::NUM_BANKS; g++)
        begin
            sps_we[g]    = 1'b0;
            pps_we[g]    = 1'b0;
            sps_wrow[g]  = '0;
            pps_wrow[g]  = '0;
            sps_wdata[g] = '0;
            pps_wdata[g] = '0;
            for (int j = 0; j < apsx_pkg::NUM_SLOTS; j++)
            begin
                if (st_req && slot[j].we &&
                    (slot[j].addr[apsx_pkg::BANK_AW-1:0] == apsx_pkg::BANK_AW'(g)))
                begin
                    if (slot[j].to_pps)
                    begin
                        pps_we[g]    = 1'b1;
                        pps_wrow[g]  = slot[j].addr[apsx_pkg::SET_AW-1:apsx_pkg::BANK_AW];
                        pps_wdata[g] = slot[j].data;
                    end
                    else
                    begin
                        sps_we[g]    = 1'b1;
                        sps_wrow[g]  = slot[j].addr[apsx_pkg::SET_AW-1:apsx_pkg::BANK_AW];
                        sps_wdata[g] = slot[j].data;
                    end
                end
            end
        end
    end

    // Next state of parser, window and readout
    always_comb
    begin
        proc_next  = proc_reg;
        win_next   = win_reg;
        fill_next  = fill_reg;
        idx_next   = idx_reg;
        ready_next = ready_reg;
        if (st_req)
        begin
            win_next   = nwin;
            fill_next  = req.last_byte ? '0 : nfill;
            proc_next  = req.last_byte ? fin_clr : fin;
            idx_next   = '0;
            ready_next = req.last_byte && (end_status == apsx_pkg::ST_OK);
        end
        else if (rd_req && ready_reg)
        begin
            idx_next   = rd_last ? '0 : idx_reg + apsx_pkg::len_t'(1);
            ready_next = !rd_last;
        end
    end

    // Read addresses for the byte after this cycle's index
    always_comb
    begin
        sps_ra_full = (idx_next < apsx_pkg::len_t'(4)) ? idx_next :
                      idx_next - apsx_pkg::len_t'(8);
        pps_ra_full = idx_next - apsx_pkg::REC_FIXED - apsx_pkg::len_t'(proc_next.sps_cnt);
        sps_raddr   = sps_ra_full[apsx_pkg::SET_AW-1:0];
        pps_raddr   = pps_ra_full[apsx_pkg::SET_AW-1:0];
    end

    // Banked parameter-set stores
    for (genvar g = 0; g < apsx_pkg::NUM_BANKS; g++)
    begin : g_bank
        apsx_pkg::byte_t sps_mem [apsx_pkg::BANK_ROWS];
        apsx_pkg::byte_t pps_mem [apsx_pkg::BANK_ROWS];
        apsx_pkg::byte_t sps_q_reg;
        apsx_pkg::byte_t pps_q_reg;

        always_ff @(posedge clk)
        begin
            if (sps_we[g])
            begin
                sps_mem[sps_wrow[g]] <= sps_wdata[g];
            end
            sps_q_reg <= sps_mem[sps_raddr[apsx_pkg::SET_AW-1:apsx_pkg::BANK_AW]];
        end

        always_ff @(posedge clk)
        begin
            if (pps_we[g])
            begin
                pps_mem[pps_wrow[g]] <= pps_wdata[g];
            end
            pps_q_reg <= pps_mem[pps_raddr[apsx_pkg::SET_AW-1:apsx_pkg::BANK_AW]];
        end

        assign sps_bank_q[g] = sps_q_reg;
        assign pps_bank_q[g] = pps_q_reg;
    end

    always_ff @(posedge clk)
    begin
        sps_bsel_reg <= sps_raddr[apsx_pkg::BANK_AW-1:0];
        pps_bsel_reg <= pps_raddr[apsx_pkg::BANK_AW-1:0];
    end

    // Record byte at the current index
    always_comb
    begin
        s_ext   = apsx_pkg::len_t'(proc_reg.sps_cnt);
        p_ext   = apsx_pkg::len_t'(proc_reg.pps_cnt);
        rec_len = apsx_pkg::REC_FIXED + s_ext + p_ext;
        sps_q   = sps_bank_q[sps_bsel_reg];
        pps_q   = pps_bank_q[pps_bsel_reg];
        if (idx_reg == '0)
        begin
            rd_byte = apsx_pkg::REC_VERSION;
        end
        else if (idx_reg < apsx_pkg::len_t'(4))
        begin
            rd_byte = sps_q;
        end
        else if (idx_reg == apsx_pkg::len_t'(4))
        begin
            rd_byte = apsx_pkg::REC_LEN_SIZE;
        end
        else if (idx_reg == apsx_pkg::len_t'(5))
        begin
            rd_byte = apsx_pkg::REC_NUM_SPS;
        end
        else if (idx_reg == apsx_pkg::len_t'(6))
        begin
            rd_byte = apsx_pkg::byte_t'(s_ext >> 8);
        end
        else if (idx_reg == apsx_pkg::len_t'(7))
        begin
            rd_byte = s_ext[7:0];
        end
        else if (idx_reg < apsx_pkg::len_t'(8) + s_ext)
        begin
            rd_byte = sps_q;
        end
        else if (idx_reg == apsx_pkg::len_t'(8) + s_ext)
        begin
            rd_byte = apsx_pkg::REC_NUM_PPS;
        end
        else if (idx_reg == apsx_pkg::len_t'(9) + s_ext)
        begin
            rd_byte = apsx_pkg::byte_t'(p_ext >> 8);
        end
        else if (idx_reg == apsx_pkg::len_t'(10) + s_ext)
        begin
            rd_byte = p_ext[7:0];
        end
        else
        begin
            rd_byte = pps_q;
        end
        rd_last = ({1'b0, idx_reg} + 11'd1) >= {1'b0, rec_len};
    end

    // Result of this request
    always_comb
    begin
        push = rd_req || (st_req && req.last_byte);
        if (rd_req)
        begin
            if (ready_reg)
            begin
                res_in = '{status: apsx_pkg::ST_OK, length: rec_len,
                           rbyte: rd_byte, rlast: rd_last};
            end
            else
            begin
                res_in = '{status: apsx_pkg::ST_NO_RECORD, length: '0,
                           rbyte: '0, rlast: 1'b0};
            end
        end
        else
        begin
            res_in = '{status: end_status, length: end_len, rbyte: '0, rlast: 1'b0};
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            proc_reg <= '{found_sps: 1'b0, found_pps: 1'b0, done: 1'b0,
                          target: apsx_pkg::TGT_NONE, at_first: 1'b0,
                          sps_cnt: '0, pps_cnt: '0};
            fill_reg  <= '0;
            idx_reg   <= '0;
            ready_reg <= 1'b0;
        end
        else
        begin
            proc_reg  <= proc_next;
            fill_reg  <= fill_next;
            idx_reg   <= idx_next;
            ready_reg <= ready_next;
        end
    end

    // Window bytes
    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

    // Two-entry result queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (rsp_fire)
            begin
                rptr_reg <= !rptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(rsp_fire);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wptr_reg] <= res_in;
        end
    end

    assign req.ready         = (cnt_reg != 2'd2);
    assign rsp.valid         = (cnt_reg != 2'd0);
    assign rsp.status        = q_reg[rptr_reg].status;
    assign rsp.record_length = q_reg[rptr_reg].length;
    assign rsp.record_byte   = q_reg[rptr_reg].rbyte;
    assign rsp.record_last   = q_reg[rptr_reg].rlast;

endmodule

[rtl/core/apsx_checker.sv]
`timescale 1ns / 1ps
// ============================================================================
// apsx_checker: port-level checks for the parameter-set extractor
// Watches the request and result channels and flags result timing errors.
// ============================================================================
module apsx_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input logic              req_func,
    input logic              req_last_byte,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input apsx_pkg::status_t rsp_status,
    input apsx_pkg::len_t    rsp_record_length,
    input apsx_pkg::byte_t   rsp_record_byte,
    input logic              rsp_record_last
);

    // A read or a final stream byte into an empty queue shows a result next
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_func == apsx_pkg::FUNC_READ || req_last_byte) &&
        !rsp_valid |=> rsp_valid)
        else $error("no result after read or end of buffer");

    // A mid-buffer stream byte never produces a result
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_func == apsx_pkg::FUNC_STREAM && !req_last_byte &&
        !rsp_valid |=> !rsp_valid)
        else $error("result produced by a mid-buffer stream byte");

    // Stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
        $stable(rsp_record_length) && $stable(rsp_record_byte) && $stable(rsp_record_last))
        else $error("stalled result changed");

endmodule

bind annexb_param_set_extractor_unit apsx_checker u_apsx_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req.valid),
    .req_ready         (req.ready),
    .req_func          (req.func),
    .req_last_byte     (req.last_byte),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_status        (rsp.status),
    .rsp_record_length (rsp.record_length),
    .rsp_record_byte   (rsp.record_byte),
    .rsp_record_last   (rsp.record_last)
);
